FILE: sv/tcw_pkg.sv
// Shared types and constants of the text console cell writer.
// Item structs, cell layout, operation and register codes, geometry helpers.
// No dependencies.
package tcw_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 32;
  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CELL_W      = 16;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [6:0]  target_column;
    logic [4:0]  target_row;
    logic [11:0] cell_index;
  } tcw_in_t;

  typedef struct packed {
    logic [11:0] cursor_position;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
  } tcw_out_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] chr;
  } tcw_cell_t;

  localparam logic [1:0] FUNC_PUT    = 2'd0;
  localparam logic [1:0] FUNC_SETPOS = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] BLANK_CHAR   = 8'h0F;

  localparam tcw_cell_t BLANK_CELL = '{attr: 8'h00, chr: BLANK_CHAR};

  // zero acts as one, above the maximum acts as the maximum
  function automatic logic [7:0] eff_columns(input logic [7:0] v);
    logic [7:0] r;
    if (v == 8'd0) r = 8'd1;
    else if (v > 8'(MAX_COLUMNS)) r = 8'(MAX_COLUMNS);
    else r = v;
    return r;
  endfunction

  function automatic logic [5:0] eff_rows(input logic [5:0] v);
    logic [5:0] r;
    if (v == 6'd0) r = 6'd1;
    else if (v > 6'(MAX_ROWS)) r = 6'(MAX_ROWS);
    else r = v;
    return r;
  endfunction

endpackage

FILE: sv/text_console_cell_writer.sv
// Text console cell writer: screen store with cursor, wrap and scroll.
// Depends on tcw_pkg and tcw_ram.
//
//  channel  signals                         direction  payload
//  in       in_valid / in_ready / in_data    input      tcw_pkg::tcw_in_t
//  out      out_valid / out_ready / out_data output     tcw_pkg::tcw_out_t
//  cfg      cfg_we / cfg_index / cfg_wdata   input      8-bit register write
//
// An item is accepted (store read issued from cell_index), then executed.
// A put that scrolls then makes one RAM port pass that copies each cell
// up by one row and blanks the bottom row.
// After reset a clearing pass writes all 4096 cells, one per cycle; in_ready
// stays low during it. One finished result is held in the output register; the
// next item is accepted meanwhile and its result waits until the register frees.
module text_console_cell_writer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcw_pkg::tcw_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tcw_pkg::tcw_out_t  out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_wdata
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_EXEC   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_FLUSH  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [11:0]         clr_r;
  logic [11:0]         scr_r;
  logic                sw_vld_r;
  logic                sw_blank_r;
  logic [11:0]         sw_addr_r;
  tcw_pkg::tcw_in_t    item_r;
  logic [4:0]          row_r, row_nxt;
  logic [6:0]          col_r, col_nxt;
  logic [7:0]          cols_r;
  logic [5:0]          rows_r;
  tcw_pkg::tcw_cell_t  rd_r;
  logic                out_valid_r;
  tcw_pkg::tcw_out_t   out_data_r;

  logic [7:0]          cols_eff;
  logic [5:0]          rows_eff;
  logic [13:0]         area;
  logic [13:0]         moved;
  logic                scr_last;
  logic                scr_blank;
  logic                slot_free;
  logic                scroll;
  tcw_pkg::tcw_cell_t  exec_rd;
  logic [5:0]          r_w;
  logic [7:0]          c_w;
  logic [7:0]          cfg_cols;
  logic [5:0]          cfg_rows;

  logic                      ram_we, ram_re;
  logic [tcw_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  tcw_pkg::tcw_cell_t        ram_wdata;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;
  tcw_pkg::tcw_cell_t        rcell;

  function automatic logic [11:0] lin_pos(input logic [4:0] row, input logic [6:0] col,
                                          input logic [7:0] cols);
    logic [12:0] p;
    p = {8'd0, row} * {5'd0, cols};
    return 12'(p + {6'd0, col});
  endfunction

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rcell     = tcw_pkg::tcw_cell_t'(ram_rdata);
  assign cols_eff  = tcw_pkg::eff_columns(cols_r);
  assign rows_eff  = tcw_pkg::eff_rows(rows_r);
  assign area      = {6'd0, cols_eff} * {8'd0, rows_eff};
  assign moved     = area - {6'd0, cols_eff};
  assign scr_last  = ({2'b00, scr_r} == (area - 14'd1));
  assign scr_blank = ({2'b00, scr_r} >= moved);
  assign slot_free = !out_valid_r || out_ready;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // cursor update of the executing item, then saturation by a register write
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    scroll   = 1'b0;
    exec_rd  = '0;
    r_w      = {1'b0, row_r};
    c_w      = {1'b0, col_r};
    cfg_cols = tcw_pkg::eff_columns(cfg_wdata);
    cfg_rows = tcw_pkg::eff_rows(cfg_wdata[5:0]);
    if (state_r == ST_EXEC) begin
      case (item_r.func)
        tcw_pkg::FUNC_PUT: begin
          if (item_r.char_code == tcw_pkg::NEWLINE_CODE) begin
            r_w = {1'b0, row_r} + 6'd1;
            c_w = 8'd0;
          end else begin
            c_w = {1'b0, col_r} + 8'd1;
          end
          if (c_w >= cols_eff) begin
            r_w = r_w + 6'd1;
            c_w = 8'd0;
          end
          if (r_w >= rows_eff) begin
            scroll  = 1'b1;
            row_nxt = 5'(rows_eff - 6'd1);
            col_nxt = 7'd0;
          end else begin
            row_nxt = r_w[4:0];
            col_nxt = c_w[6:0];
          end
        end
        tcw_pkg::FUNC_SETPOS: begin
          col_nxt = ({1'b0, item_r.target_column} >= cols_eff) ?
                    7'(cols_eff - 8'd1) : item_r.target_column;
          row_nxt = ({1'b0, item_r.target_row} >= rows_eff) ?
                    5'(rows_eff - 6'd1) : item_r.target_row;
        end
        tcw_pkg::FUNC_READ: begin
          if ({2'b00, item_r.cell_index} < area) begin
            exec_rd = rcell;
          end
        end
        default: ;
      endcase
    end
    if (cfg_we) begin
      case (cfg_index)
        tcw_pkg::CFG_COLUMNS: begin
          if ({1'b0, col_nxt} >= cfg_cols) col_nxt = 7'(cfg_cols - 8'd1);
        end
        tcw_pkg::CFG_ROWS: begin
          if ({1'b0, row_nxt} >= cfg_rows) row_nxt = 5'(cfg_rows - 6'd1);
        end
        default: ;
      endcase
    end
  end

  // store ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
    end else if (state_r == ST_EXEC && item_r.func == tcw_pkg::FUNC_PUT) begin
      ram_we    = 1'b1;
      ram_waddr = lin_pos(row_r, col_r, cols_eff);
      if (item_r.char_code == tcw_pkg::NEWLINE_CODE) begin
        ram_wdata = '{attr: 8'h00, chr: tcw_pkg::SPACE_CODE};
      end else begin
        ram_wdata = '{attr: {item_r.bg_color, item_r.fg_color}, chr: item_r.char_code};
      end
    end else if (sw_vld_r) begin
      ram_we    = 1'b1;
      ram_waddr = sw_addr_r;
      ram_wdata = sw_blank_r ? tcw_pkg::BLANK_CELL : rcell;
    end
    if (state_r == ST_IDLE) begin
      ram_re    = 1'b1;
      ram_raddr = in_data.cell_index;
    end else if (state_r == ST_SCROLL) begin
      // source cell one row below; beyond the area the data is not used
      ram_re    = 1'b1;
      ram_raddr = scr_r + {4'd0, cols_eff};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_r == '1) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (scroll) state_nxt = ST_SCROLL;
        else if (slot_free) state_nxt = ST_IDLE;
        else state_nxt = ST_DONE;
      end
      ST_SCROLL: if (scr_last) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      scr_r       <= '0;
      sw_vld_r    <= 1'b0;
      row_r       <= '0;
      col_r       <= '0;
      cols_r      <= 8'd80;
      rows_r      <= 6'd25;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      sw_vld_r <= (state_r == ST_SCROLL);
      if (state_r == ST_CLEAR) clr_r <= clr_r + 12'd1;
      if (state_r == ST_EXEC) scr_r <= '0;
      else if (state_r == ST_SCROLL) scr_r <= scr_r + 12'd1;
      if (cfg_we) begin
        case (cfg_index)
          tcw_pkg::CFG_COLUMNS: cols_r <= cfg_wdata;
          tcw_pkg::CFG_ROWS:    rows_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if ((state_r == ST_EXEC && !scroll && slot_free) ||
          (state_r == ST_DONE && slot_free)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sw_addr_r  <= scr_r;
    sw_blank_r <= scr_blank;
    if (in_valid && in_ready) item_r <= in_data;
    if (state_r == ST_EXEC) rd_r <= exec_rd;
    if (state_r == ST_EXEC && !scroll && slot_free) begin
      out_data_r.cursor_position <= lin_pos(row_nxt, col_nxt, cols_eff);
      out_data_r.read_char       <= exec_rd.chr;
      out_data_r.read_attr       <= exec_rd.attr;
    end else if (state_r == ST_DONE && slot_free) begin
      out_data_r.cursor_position <= lin_pos(row_r, col_r, cols_eff);
      out_data_r.read_char       <= rd_r.chr;
      out_data_r.read_attr       <= rd_r.attr;
    end
  end

endmodule

FILE: sv/tcw_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for text_console_cell_writer: directed cases, then random traffic.
// Needs tcw_pkg and the block's RTL; keeps its own screen and cursor shadow to score results.
module tb_top;

  localparam int LIMIT_CYCLES  = 10_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASES        = 12;

  localparam logic [1:0]        FUNC_NOP   = 2'd3;
  localparam logic [7:0]        LF_CODE    = tcw_pkg::NEWLINE_CODE;
  localparam logic [7:0]        BLANK_CODE = tcw_pkg::SPACE_CODE;
  localparam tcw_pkg::tcw_cell_t EMPTY_CELL = tcw_pkg::BLANK_CELL;

  typedef logic [tcw_pkg::ADDR_W-1:0] cell_addr_t;

  typedef struct packed {
    logic              is_geom;
    logic [7:0]        geom_cols;
    logic [7:0]        geom_rows;
    tcw_pkg::tcw_in_t  item;
    logic              typed;
    tcw_pkg::tcw_out_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  tcw_pkg::tcw_in_t   in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  tcw_pkg::tcw_out_t  out_data;
  logic               cfg_we;
  logic               cfg_index;
  logic [7:0]         cfg_wdata;

  // shadow of the screen store, cursor and geometry registers
  tcw_pkg::tcw_cell_t shadow_cells [tcw_pkg::CELLS];
  int                 cur_row;
  int                 cur_col;
  logic [7:0]         reg_cols;
  logic [5:0]         reg_rows;

  tcw_pkg::tcw_out_t console_expect [$];
  tcw_pkg::tcw_out_t head_expect;
  plan_row_t         plan [$];

  int send_idle_pct = 38;
  int recv_idle_pct = 66;
  int error_count   = 0;
  int cycle_count   = 0;
  int result_count  = 0;
  int burst_len;

  logic [7:0] phase_cols [PHASES] = '{8'd80, 8'd1, 8'd128, 8'd0, 8'd7, 8'd255,
                                      8'd16, 8'd1, 8'd40, 8'd129, 8'd5, 8'd12};
  logic [7:0] phase_rows [PHASES] = '{8'd25, 8'd1, 8'd32, 8'd0, 8'd3, 8'd63,
                                      8'd1, 8'd32, 8'd12, 8'd33, 8'd200, 8'd6};

  text_console_cell_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_cols();
    if (reg_cols == 8'd0) return 1;
    if (reg_cols > 8'(tcw_pkg::MAX_COLUMNS)) return tcw_pkg::MAX_COLUMNS;
    return int'(reg_cols);
  endfunction

  function automatic int live_rows();
    if (reg_rows == 6'd0) return 1;
    if (reg_rows > 6'(tcw_pkg::MAX_ROWS)) return tcw_pkg::MAX_ROWS;
    return int'(reg_rows);
  endfunction

  function automatic void clamp_cursor();
    if (cur_col >= live_cols()) cur_col = live_cols() - 1;
    if (cur_row >= live_rows()) cur_row = live_rows() - 1;
  endfunction

  // apply one item to the shadow and return the result it must produce
  function automatic tcw_pkg::tcw_out_t predict_console(input tcw_pkg::tcw_in_t it);
    tcw_pkg::tcw_out_t res;
    int cols;
    int rows;
    int idx;
    clamp_cursor();
    cols = live_cols();
    rows = live_rows();
    res  = '0;
    case (it.func)
      tcw_pkg::FUNC_PUT: begin
        idx = cur_row * cols + cur_col;
        if (it.char_code == LF_CODE) begin
          shadow_cells[cell_addr_t'(idx)] = '{attr: 8'h00, chr: BLANK_CODE};
          cur_row++;
          cur_col = 0;
        end else begin
          shadow_cells[cell_addr_t'(idx)] = '{attr: {it.bg_color, it.fg_color},
                                              chr: it.char_code};
          cur_col++;
        end
        if (cur_col >= cols) begin
          cur_row++;
          cur_col = 0;
        end
        if (cur_row >= rows) begin
          // shift every row up by one, blank the bottom row
          for (int i = 0; i < cols * (rows - 1); i++) begin
            shadow_cells[cell_addr_t'(i)] = shadow_cells[cell_addr_t'(i + cols)];
          end
          for (int i = 0; i < cols; i++) begin
            shadow_cells[cell_addr_t'(cols * (rows - 1) + i)] = EMPTY_CELL;
          end
          cur_col = 0;
          cur_row = rows - 1;
        end
      end
      tcw_pkg::FUNC_SETPOS: begin
        cur_col = (int'(it.target_column) >= cols) ? cols - 1 : int'(it.target_column);
        cur_row = (int'(it.target_row) >= rows) ? rows - 1 : int'(it.target_row);
      end
      tcw_pkg::FUNC_READ: begin
        if (int'(it.cell_index) < cols * rows) begin
          res.read_char = shadow_cells[it.cell_index].chr;
          res.read_attr = shadow_cells[it.cell_index].attr;
        end
      end
      default: ;
    endcase
    res.cursor_position = 12'(cur_row * cols + cur_col);
    return res;
  endfunction

  function automatic plan_row_t step_row(input logic [1:0] f, input int ch,
                                         input int fg, input int bg,
                                         input int tc, input int tr,
                                         input int ci, input int typed,
                                         input int pos, input int rc,
                                         input int ra);
    plan_row_t r;
    r = '0;
    r.item.func          = f;
    r.item.char_code     = 8'(ch);
    r.item.fg_color      = 4'(fg);
    r.item.bg_color      = 4'(bg);
    r.item.target_column = 7'(tc);
    r.item.target_row    = 5'(tr);
    r.item.cell_index    = 12'(ci);
    r.typed              = (typed != 0);
    r.want.cursor_position = 12'(pos);
    r.want.read_char       = 8'(rc);
    r.want.read_attr       = 8'(ra);
    return r;
  endfunction

  function automatic plan_row_t geom_row(input logic [7:0] c, input logic [7:0] r);
    plan_row_t g;
    g = '0;
    g.is_geom   = 1'b1;
    g.geom_cols = c;
    g.geom_rows = r;
    return g;
  endfunction

  // mostly text with line breaks, cursor moves and reads of the live area; some wild values
  function automatic tcw_pkg::tcw_in_t random_op();
    tcw_pkg::tcw_in_t it;
    int pick;
    int cols;
    int rows;
    cols = live_cols();
    rows = live_rows();
    it.func          = 2'($urandom);
    it.char_code     = 8'($urandom);
    it.fg_color      = 4'($urandom);
    it.bg_color      = 4'($urandom);
    it.target_column = 7'($urandom);
    it.target_row    = 5'($urandom);
    it.cell_index    = 12'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) begin
      it.func = tcw_pkg::FUNC_PUT;
      if ($urandom_range(7) == 0) it.char_code = LF_CODE;
    end else if (pick < 70) begin
      it.func = tcw_pkg::FUNC_SETPOS;
      if ($urandom_range(9) < 7) begin
        it.target_column = 7'($urandom_range(cols - 1));
        it.target_row    = 5'($urandom_range(rows - 1));
      end
    end else if (pick < 95) begin
      it.func = tcw_pkg::FUNC_READ;
      if ($urandom_range(9) < 7) it.cell_index = 12'($urandom_range(cols * rows - 1));
    end else begin
      it.func = FUNC_NOP;
    end
    return it;
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  task automatic send_item(input tcw_pkg::tcw_in_t item, input logic typed,
                           input tcw_pkg::tcw_out_t typed_result);
    tcw_pkg::tcw_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_console(item);
    console_expect.push_back(typed ? typed_result : predicted);
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (console_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_geometry(input logic [7:0] cols, input logic [7:0] rows);
    cfg_we    <= 1'b1;
    cfg_index <= tcw_pkg::CFG_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= tcw_pkg::CFG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_cols = cols;
    clamp_cursor();
    reg_rows = rows[5:0];
    clamp_cursor();
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (console_expect.size() == 0) begin
        flag_error($sformatf("unexpected result: pos %0d chr %02h attr %02h",
                             out_data.cursor_position, out_data.read_char,
                             out_data.read_attr));
      end else begin
        head_expect = console_expect.pop_front();
        if (out_data.cursor_position !== head_expect.cursor_position ||
            out_data.read_char !== head_expect.read_char ||
            out_data.read_attr !== head_expect.read_attr) begin
          flag_error($sformatf(
            "result %0d: expected pos %0d chr %02h attr %02h, got pos %0d chr %02h attr %02h",
            result_count, head_expect.cursor_position, head_expect.read_char,
            head_expect.read_attr, out_data.cursor_position, out_data.read_char,
            out_data.read_attr));
        end
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("text_console_cell_writer regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= tcw_pkg::CFG_COLUMNS;
    cfg_wdata <= 8'd0;
    for (int i = 0; i < tcw_pkg::CELLS; i++) shadow_cells[cell_addr_t'(i)] = EMPTY_CELL;
    cur_row  = 0;
    cur_col  = 0;
    reg_cols = 8'd80;
    reg_rows = 6'd25;

    // reset geometry is 80 x 25
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 0, 'h0F, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1999, 1, 0, 'h0F, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 2000, 1, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 'hFFF, 1, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, 'h41, 'hF, 'hF, 0, 0, 0, 1, 1, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 1, 'h41, 'hFF));
    // saturating cursor move, then a put in the last cell wraps and scrolls
    plan.push_back(step_row(tcw_pkg::FUNC_SETPOS, 0, 0, 0, 127, 31, 0, 1, 1999, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, 'hFF, 0, 0, 0, 0, 0, 1, 1920, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1919, 1, 1920, 'hFF, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1920, 1, 1920, 'h0F, 0));
    // newline on the bottom row leaves a space and scrolls
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, int'(LF_CODE), 'hF, 'hF, 0, 0, 0, 1, 1920,
                            0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1840, 1, 1920, 'h20, 0));
    plan.push_back(step_row(FUNC_NOP, 'hFF, 'hF, 'hF, 127, 31, 'hFFF, 1, 1920, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_SETPOS, 'hFF, 'hF, 'hF, 0, 0, 'hFFF, 1, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, 'h00, 'hF, 'h0, 127, 31, 'hFFF, 0, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, int'(LF_CODE), 0, 0, 0, 0, 0, 0, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 'hAA, 'h5, 'hA, 85, 10, 0, 0, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_SETPOS, 0, 0, 0, 5, 3, 0, 1, 245, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, 'h80, 'h0, 'hF, 0, 0, 0, 0, 0, 0, 0));
    // zero registers act as a single cell screen
    plan.push_back(geom_row(8'd0, 8'd0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, 'h55, 'h3, 'hC, 0, 0, 0, 1, 0, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 1, 0, 'h0F, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0));
    // oversized registers act as the full store
    plan.push_back(geom_row(8'd255, 8'd63));
    plan.push_back(step_row(tcw_pkg::FUNC_SETPOS, 0, 0, 0, 127, 31, 0, 1, 4095, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 4095, 1, 4095, 'h0F, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_PUT, 'h7E, 'h5, 'hA, 0, 0, 0, 1, 3968, 0, 0));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 3967, 1, 3968, 'h7E, 'hA5));
    // shrinking pulls the cursor in; the store is read linearly under the new shape
    plan.push_back(geom_row(8'd3, 8'd2));
    plan.push_back(step_row(tcw_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_geom) begin
        wait_drained();
        program_geometry(plan[i].geom_cols, plan[i].geom_rows);
      end else begin
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase == 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 38;
      end else if (phase == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_geometry(phase_cols[phase], phase_rows[phase]);
      // full-size screens scroll slowly, keep those bursts short
      burst_len = (live_cols() * live_rows() > 1024) ? 40 : 133;
      repeat (burst_len) send_item(random_op(), 1'b0, '0);
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("text_console_cell_writer regression: pass");
    end else begin
      $display("text_console_cell_writer regression: fail");
    end
    $finish;
  end

endmodule
